/* sv/quic_path_validation_table_unit_macros.svh */
// Assertion macros for the QUIC path validation table unit.
// Expects clk and rst_n in the scope of every use.
`ifndef QUIC_PATH_VALIDATION_TABLE_UNIT_MACROS_SVH
`define QUIC_PATH_VALIDATION_TABLE_UNIT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define QPV_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qpv assertion failed");

// antecedent implies consequent in the next cycle
`define QPV_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qpv assertion failed");

`endif

/* sv/qpv_pkg.sv */
// Shared types, codes and helpers of the QUIC path validation table unit.
// No dependencies; imported by every module of the block.
`default_nettype none

package qpv_pkg;

  localparam int MAX_PATHS = 4;
  localparam int PW = (MAX_PATHS > 1) ? $clog2(MAX_PATHS) : 1;
  localparam int CW = $clog2(MAX_PATHS + 1);
  localparam int FLD_PATH_W = 2;
  localparam int FLD_TCNT_W = 3;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 16;

  // event kinds
  localparam logic [2:0] K_INIT  = 3'd0;
  localparam logic [2:0] K_PROBE = 3'd1;
  localparam logic [2:0] K_RESP  = 3'd2;
  localparam logic [2:0] K_TICK  = 3'd3;
  localparam logic [2:0] K_PEER  = 3'd4;
  localparam logic [2:0] K_MIG   = 3'd5;

  // result status
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_LIMIT   = 2'd2;
  localparam logic [1:0] ST_NOTALL  = 2'd3;

  // path states
  localparam logic [2:0] PS_UNKNOWN   = 3'd0;
  localparam logic [2:0] PS_VALIDATING = 3'd1;
  localparam logic [2:0] PS_VALIDATED = 3'd2;
  localparam logic [2:0] PS_FAILED    = 3'd3;
  localparam logic [2:0] PS_ABANDONED = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROLE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VTO  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAXC = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NRW  = 4'd3;

  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] peer_addr_hi;
    logic [63:0] peer_addr_lo;
    logic [15:0] peer_port;
    logic        peer_is_v6;
    logic [63:0] chal_word;
    logic [63:0] now_ms;
    logic [1:0]  path_index;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  result_path;
    logic        send_challenge;
    logic [63:0] challenge_out;
    logic [2:0]  path_state;
    logic [1:0]  active_index;
    logic        nat_rebinding;
    logic [2:0]  fail_count;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic [15:0] port;
    logic        is_v6;
    logic [63:0] challenge;
    logic [2:0]  state;
    logic [3:0]  retries;
    logic [63:0] sent_time;
  } slot_t;

  typedef struct packed {
    logic        role;
    logic [15:0] vto;
    logic [3:0]  maxc;
    logic [15:0] nrw;
  } cfg_t;

  typedef struct packed {
    logic          rd_en;
    logic [PW-1:0] rd_addr;
    logic          wr_en;
    logic [PW-1:0] wr_addr;
    slot_t         wr_data;
  } ram_req_t;

  // family, port and address compare; IPv4 looks at the low 32 bits only
  function automatic logic addr_match(slot_t s, in_t it);
    logic ok;
    ok = (s.is_v6 == it.peer_is_v6) && (s.port == it.peer_port);
    if (it.peer_is_v6) begin
      ok = ok && (s.addr_hi == it.peer_addr_hi) && (s.addr_lo == it.peer_addr_lo);
    end else begin
      ok = ok && (s.addr_lo[31:0] == it.peer_addr_lo[31:0]);
    end
    return ok;
  endfunction

  // rotate left by 8 times the slot index, modulo 64
  function automatic logic [63:0] rotl8(logic [63:0] c, logic [PW-1:0] i);
    logic [5:0] sh;
    sh = {3'(i), 3'b000};
    return (c << sh) | (c >> (7'd64 - {1'b0, sh}));
  endfunction

endpackage

`default_nettype wire

/* sv/qpv_slot_ram.sv */
// Slot table memory: one write and one registered read port.
// Per-entry valid bits make unwritten entries read as zero. Uses qpv_pkg.
`default_nettype none

module qpv_slot_ram import qpv_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire ram_req_t req,
  output slot_t         rdata
);

  slot_t                 mem [MAX_PATHS];
  logic [MAX_PATHS-1:0]  valid_r;
  slot_t                 rdata_r;

  // storage write
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // valid bits, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (req.wr_en) begin
      valid_r[req.wr_addr] <= 1'b1;
    end
  end

  // registered read, holds when idle
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rdata_r <= valid_r[req.rd_addr] ? mem[req.rd_addr] : '0;
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* sv/qpv_ctrl.sv */
// Event sequencer: scans the slot memory one entry at a time, updates it
// and hands result words to the output stage. Uses qpv_pkg.
`default_nettype none

module qpv_ctrl import qpv_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire in_t      in_data,
  output logic          in_ready,
  input  wire cfg_t     cfg,
  input  wire logic     res_ready,
  output logic          res_valid,
  output out_t          res_data,
  output ram_req_t      ram_req,
  input  wire slot_t    ram_rdata
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_DISP = 7'b0000010,
    S_RD   = 7'b0000100,
    S_CHK  = 7'b0001000,
    S_END  = 7'b0010000,
    S_FRD  = 7'b0100000,
    S_FIN  = 7'b1000000
  } state_t;

  state_t        state_r, state_nxt;
  logic [2:0]    op_r, op_nxt;
  in_t           item_r, item_nxt;
  logic [PW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] used_r, used_nxt;
  logic [PW-1:0] active_r, active_nxt;
  logic          nat_r, nat_nxt;
  logic [63:0]   lct_r, lct_nxt;
  logic          fnd_r, fnd_nxt;
  logic [PW-1:0] ruse_r, ruse_nxt;
  logic [CW-1:0] fail_r, fail_nxt;
  logic [1:0]    e_status_r, e_status_nxt;
  logic [PW-1:0] e_path_r, e_path_nxt;
  logic          e_send_r, e_send_nxt;
  logic [63:0]   e_chal_r, e_chal_nxt;
  logic [CW-1:0] e_tcnt_r, e_tcnt_nxt;

  slot_t         rd;
  slot_t         fresh;
  slot_t         upd;
  logic          scan_last;
  logic          aged;
  logic [PW-1:0] target;
  logic [63:0]   rot;

  assign rd        = ram_rdata;
  assign target    = PW'(item_r.path_index);
  assign scan_last = (CW'(idx_r) + CW'(1)) >= used_r;
  assign aged      = (item_r.now_ms - rd.sent_time) >= 64'(cfg.vto);
  assign rot       = rotl8(item_r.chal_word, idx_r);

  // record for a freshly probed address
  always_comb begin
    fresh           = '0;
    fresh.addr_hi   = item_r.peer_addr_hi;
    fresh.addr_lo   = item_r.peer_addr_lo;
    fresh.port      = item_r.peer_port;
    fresh.is_v6     = item_r.peer_is_v6;
    fresh.challenge = item_r.chal_word;
    fresh.state     = PS_VALIDATING;
    fresh.retries   = 4'd1;
    fresh.sent_time = item_r.now_ms;
  end

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    item_nxt     = item_r;
    idx_nxt      = idx_r;
    used_nxt     = used_r;
    active_nxt   = active_r;
    nat_nxt      = nat_r;
    lct_nxt      = lct_r;
    fnd_nxt      = fnd_r;
    ruse_nxt     = ruse_r;
    fail_nxt     = fail_r;
    e_status_nxt = e_status_r;
    e_path_nxt   = e_path_r;
    e_send_nxt   = e_send_r;
    e_chal_nxt   = e_chal_r;
    e_tcnt_nxt   = e_tcnt_r;
    ram_req      = '0;
    res_valid    = 1'b0;
    res_data     = '0;
    upd          = rd;
    in_ready     = (state_r == S_IDLE);

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt   = in_data;
          op_nxt     = in_data.kind;
          idx_nxt    = '0;
          fnd_nxt    = 1'b0;
          fail_nxt   = '0;
          e_send_nxt = 1'b0;
          e_tcnt_nxt = '0;
          state_nxt  = S_DISP;
        end
      end

      S_DISP: begin
        state_nxt    = S_FRD;
        e_status_nxt = ST_INVALID;
        e_path_nxt   = active_r;
        case (op_r)
          K_INIT: begin
            if (used_r >= CW'(MAX_PATHS)) begin
              e_status_nxt = ST_LIMIT;
            end else begin
              upd               = '0;
              upd.addr_hi       = item_r.peer_addr_hi;
              upd.addr_lo       = item_r.peer_addr_lo;
              upd.port          = item_r.peer_port;
              upd.is_v6         = item_r.peer_is_v6;
              upd.state         = PS_VALIDATED;
              ram_req.wr_en     = 1'b1;
              ram_req.wr_addr   = '0;
              ram_req.wr_data   = upd;
              used_nxt          = CW'(1);
              active_nxt        = '0;
              e_status_nxt      = ST_OK;
              e_path_nxt        = '0;
            end
          end
          K_PROBE, K_RESP, K_TICK: begin
            state_nxt = (used_r == '0) ? S_END : S_RD;
          end
          K_PEER: begin
            if (used_r != '0 && CW'(active_r) < used_r) begin
              idx_nxt   = active_r;
              state_nxt = S_RD;
            end
          end
          K_MIG: begin
            e_path_nxt = target;
            if (cfg.role) begin
              e_status_nxt = ST_NOTALL;
            end else if (CW'(target) < used_r) begin
              idx_nxt   = target;
              state_nxt = S_RD;
            end
          end
          default: begin
          end
        endcase
      end

      S_RD: begin
        ram_req.rd_en   = 1'b1;
        ram_req.rd_addr = idx_r;
        state_nxt       = S_CHK;
      end

      S_CHK: begin
        // default: step to the next slot or finish the scan
        state_nxt = scan_last ? S_END : S_RD;
        idx_nxt   = idx_r + PW'(1);
        case (op_r)
          K_PROBE: begin
            if (addr_match(rd, item_r)) begin
              upd.challenge   = item_r.chal_word;
              upd.state       = PS_VALIDATING;
              upd.retries     = 4'd1;
              upd.sent_time   = item_r.now_ms;
              ram_req.wr_en   = 1'b1;
              ram_req.wr_addr = idx_r;
              ram_req.wr_data = upd;
              e_status_nxt    = ST_OK;
              e_path_nxt      = idx_r;
              e_send_nxt      = 1'b1;
              e_chal_nxt      = item_r.chal_word;
              state_nxt       = S_FRD;
            end else if (!fnd_r && (rd.state inside {PS_FAILED, PS_ABANDONED})) begin
              fnd_nxt  = 1'b1;
              ruse_nxt = idx_r;
            end
          end
          K_RESP: begin
            if (rd.challenge == item_r.chal_word) begin
              e_path_nxt = idx_r;
              state_nxt  = S_FRD;
              if (rd.state != PS_VALIDATING) begin
                e_status_nxt = ST_INVALID;
              end else begin
                upd.state       = PS_VALIDATED;
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = idx_r;
                ram_req.wr_data = upd;
                e_status_nxt    = ST_OK;
              end
            end
          end
          K_TICK: begin
            if (rd.state == PS_VALIDATING && aged) begin
              if (rd.retries < cfg.maxc) begin
                // retry: send a fresh challenge now, hold until taken
                res_valid                = 1'b1;
                res_data.status          = ST_OK;
                res_data.result_path     = FLD_PATH_W'(idx_r);
                res_data.send_challenge  = 1'b1;
                res_data.challenge_out   = rot;
                res_data.path_state      = PS_VALIDATING;
                res_data.active_index    = FLD_PATH_W'(active_r);
                res_data.nat_rebinding   = nat_r;
                res_data.fail_count      = '0;
                res_data.last            = 1'b0;
                if (res_ready) begin
                  upd.retries     = rd.retries + 4'd1;
                  upd.sent_time   = item_r.now_ms;
                  upd.challenge   = rot;
                  ram_req.wr_en   = 1'b1;
                  ram_req.wr_addr = idx_r;
                  ram_req.wr_data = upd;
                end else begin
                  state_nxt = S_CHK;
                  idx_nxt   = idx_r;
                end
              end else begin
                upd.state       = PS_FAILED;
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = idx_r;
                ram_req.wr_data = upd;
                fail_nxt        = fail_r + CW'(1);
              end
            end
          end
          K_PEER: begin
            if (addr_match(rd, item_r)) begin
              e_status_nxt = ST_OK;
              e_path_nxt   = active_r;
              state_nxt    = S_FRD;
            end else begin
              if ((item_r.now_ms - lct_r) < 64'(cfg.nrw)) begin
                nat_nxt = 1'b1;
              end else begin
                lct_nxt = item_r.now_ms;
              end
              op_nxt    = K_PROBE;
              idx_nxt   = '0;
              state_nxt = S_RD;
            end
          end
          K_MIG: begin
            e_path_nxt = target;
            state_nxt  = S_FRD;
            if (rd.state == PS_VALIDATED) begin
              active_nxt   = target;
              e_status_nxt = ST_OK;
            end else begin
              e_status_nxt = ST_INVALID;
            end
          end
          default: begin
            state_nxt = S_FRD;
          end
        endcase
      end

      S_END: begin
        state_nxt    = S_FRD;
        e_status_nxt = ST_INVALID;
        e_path_nxt   = active_r;
        case (op_r)
          K_PROBE: begin
            if (!fnd_r && used_r >= CW'(MAX_PATHS)) begin
              e_status_nxt = ST_LIMIT;
            end else begin
              ram_req.wr_en   = 1'b1;
              ram_req.wr_addr = fnd_r ? ruse_r : PW'(used_r);
              ram_req.wr_data = fresh;
              if (!fnd_r) begin
                used_nxt = used_r + CW'(1);
              end
              e_status_nxt = ST_OK;
              e_path_nxt   = fnd_r ? ruse_r : PW'(used_r);
              e_send_nxt   = 1'b1;
              e_chal_nxt   = item_r.chal_word;
            end
          end
          K_TICK: begin
            e_status_nxt = ST_OK;
            e_tcnt_nxt   = fail_r;
          end
          default: begin
          end
        endcase
      end

      S_FRD: begin
        ram_req.rd_en   = 1'b1;
        ram_req.rd_addr = e_path_r;
        state_nxt       = S_FIN;
      end

      S_FIN: begin
        res_valid               = 1'b1;
        res_data.status         = e_status_r;
        res_data.result_path    = FLD_PATH_W'(e_path_r);
        res_data.send_challenge = e_send_r;
        res_data.challenge_out  = e_send_r ? e_chal_r : '0;
        res_data.path_state     = rd.state;
        res_data.active_index   = FLD_PATH_W'(active_r);
        res_data.nat_rebinding  = nat_r;
        res_data.fail_count     = FLD_TCNT_W'(e_tcnt_r);
        res_data.last           = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      used_r   <= '0;
      active_r <= '0;
      nat_r    <= 1'b0;
      lct_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      used_r   <= used_nxt;
      active_r <= active_nxt;
      nat_r    <= nat_nxt;
      lct_r    <= lct_nxt;
    end
  end

  // working registers of the current event
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    item_r     <= item_nxt;
    idx_r      <= idx_nxt;
    fnd_r      <= fnd_nxt;
    ruse_r     <= ruse_nxt;
    fail_r     <= fail_nxt;
    e_status_r <= e_status_nxt;
    e_path_r   <= e_path_nxt;
    e_send_r   <= e_send_nxt;
    e_chal_r   <= e_chal_nxt;
    e_tcnt_r   <= e_tcnt_nxt;
  end

endmodule

`default_nettype wire

/* sv/quic_path_validation_table_unit.sv */
// QUIC path validation table: one event word in, one or more result words
// out, the final one marked last. An event that scans no slot (init,
// refused migrate or peer change, unknown kind) goes from dispatch to the
// final slot read and the result; a migrate or a peer change to the same
// address reads one slot first; a probe, response or tick reads the slots
// in use one by one until a match or the end; a peer change that turns
// into a probe scans after its first read. The pace is set by the single,
// registered slot-memory read port. Timeout ticks add one result per
// retried slot, and every result waits for room in the output register.
// No clearing pass after reset: unwritten slots read as zero through valid
// bits. A new event is taken while the last result still waits in the output
// register. Depends on qpv_pkg, qpv_slot_ram, qpv_ctrl and the macro header.
`default_nettype none

`include "quic_path_validation_table_unit_macros.svh"

module quic_path_validation_table_unit import qpv_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_t                   in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_t                       out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t     cfg_r;
  logic     out_valid_r;
  out_t     out_data_r;
  logic     in_ready;
  logic     res_valid;
  logic     res_ready;
  out_t     res_data;
  ram_req_t ram_req;
  slot_t    ram_rdata;

  // configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.role <= 1'b0;
      cfg_r.vto  <= 16'd3000;
      cfg_r.maxc <= 4'd3;
      cfg_r.nrw  <= 16'd1000;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ROLE: cfg_r.role <= cfg_data[0];
        CFG_VTO:  cfg_r.vto  <= cfg_data;
        CFG_MAXC: cfg_r.maxc <= cfg_data[3:0];
        CFG_NRW:  cfg_r.nrw  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  qpv_slot_ram u_ram (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  qpv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_ready  (in_ready),
    .cfg       (cfg_r),
    .res_ready (res_ready),
    .res_valid (res_valid),
    .res_data  (res_data),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

  assign in_stall = !in_ready;

  // output register: a word moves in when empty or being taken
  assign res_ready = !out_valid_r || !out_stall;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  `QPV_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  `QPV_ASSERT_IMP(a_tcount_on_last, out_valid && out_data.fail_count != 3'd0, out_data.last)
  `QPV_ASSERT_IMP(a_mid_word_sends, out_valid && !out_data.last, out_data.send_challenge)
  `QPV_ASSERT_IMP(a_no_chal_unsent, out_valid && !out_data.send_challenge, out_data.challenge_out == 64'd0)

endmodule

`default_nettype wire

/* verif/testbench.sv */
// Self-checking testbench for quic_path_validation_table_unit.
// Depends on qpv_pkg; predicts each result word and compares it as a whole word.
`timescale 1ns / 1ps
`default_nettype none

module testbench;
  import qpv_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  quic_path_validation_table_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  slot_t tbl [MAX_PATHS];
  logic [2:0] n_used;
  logic [1:0] act;
  logic nat;
  logic [63:0] chg_time;
  cfg_t cfg;

  out_t exp_q [$];
  in_t pend_q [$];
  int mismatches = 0;
  int words_seen = 0;
  int words_sent = 0;
  int idle_cycles = 0;
  logic in_taken = 1'b0;
  logic out_taken = 1'b0;

  function automatic logic same_addr(int s, in_t it);
    if (tbl[s].is_v6 != it.peer_is_v6 || tbl[s].port != it.peer_port) return 1'b0;
    if (it.peer_is_v6)
      return tbl[s].addr_hi == it.peer_addr_hi && tbl[s].addr_lo == it.peer_addr_lo;
    return tbl[s].addr_lo[31:0] == it.peer_addr_lo[31:0];
  endfunction

  task automatic push_word(logic [1:0] st, int p, logic snd, logic [63:0] c,
                           logic [2:0] tc, logic lst);
    out_t w;
    w.status = st;
    w.result_path = p[1:0];
    w.send_challenge = snd;
    w.challenge_out = snd ? c : 64'd0;
    w.path_state = tbl[p].state;
    w.active_index = act;
    w.nat_rebinding = nat;
    w.fail_count = tc;
    w.last = lst;
    exp_q.push_back(w);
  endtask

  task automatic clear_slot(int s, in_t it);
    tbl[s] = '0;
    tbl[s].addr_hi = it.peer_addr_hi;
    tbl[s].addr_lo = it.peer_addr_lo;
    tbl[s].port = it.peer_port;
    tbl[s].is_v6 = it.peer_is_v6;
  endtask

  task automatic predict_probe(in_t it);
    int s;
    s = -1;
    for (int i = 0; i < n_used; i++)
      if (s < 0 && same_addr(i, it)) s = i;
    if (s < 0) begin
      for (int i = 0; i < n_used; i++)
        if (s < 0 && (tbl[i].state == PS_FAILED || tbl[i].state == PS_ABANDONED)) s = i;
      if (s < 0) begin
        if (n_used >= MAX_PATHS) begin
          push_word(ST_LIMIT, act, 1'b0, '0, '0, 1'b1);
          return;
        end
        s = n_used;
        n_used++;
      end
      clear_slot(s, it);
    end
    tbl[s].challenge = it.chal_word;
    tbl[s].state = PS_VALIDATING;
    tbl[s].retries = 4'd1;
    tbl[s].sent_time = it.now_ms;
    push_word(ST_OK, s, 1'b1, it.chal_word, '0, 1'b1);
  endtask

  task automatic predict_event(in_t it);
    int hit;
    logic [2:0] nfail;
    logic [63:0] rc;
    case (it.kind)
      K_INIT: begin
        if (n_used >= MAX_PATHS) push_word(ST_LIMIT, act, 1'b0, '0, '0, 1'b1);
        else begin
          clear_slot(0, it);
          tbl[0].state = PS_VALIDATED;
          n_used = 3'd1;
          act = 2'd0;
          push_word(ST_OK, 0, 1'b0, '0, '0, 1'b1);
        end
      end
      K_PROBE: predict_probe(it);
      K_RESP: begin
        hit = -1;
        for (int i = 0; i < n_used; i++)
          if (hit < 0 && tbl[i].challenge == it.chal_word) hit = i;
        if (hit < 0) push_word(ST_INVALID, act, 1'b0, '0, '0, 1'b1);
        else if (tbl[hit].state != PS_VALIDATING)
          push_word(ST_INVALID, hit, 1'b0, '0, '0, 1'b1);
        else begin
          tbl[hit].state = PS_VALIDATED;
          push_word(ST_OK, hit, 1'b0, '0, '0, 1'b1);
        end
      end
      K_TICK: begin
        nfail = '0;
        for (int i = 0; i < n_used; i++) begin
          if (tbl[i].state == PS_VALIDATING &&
              (it.now_ms - tbl[i].sent_time) >= {48'd0, cfg.vto}) begin
            if (tbl[i].retries < cfg.maxc) begin
              rc = (i == 0) ? it.chal_word :
                   ((it.chal_word << (8 * i)) | (it.chal_word >> (64 - 8 * i)));
              tbl[i].retries++;
              tbl[i].sent_time = it.now_ms;
              tbl[i].challenge = rc;
              push_word(ST_OK, i, 1'b1, rc, '0, 1'b0);
            end else begin
              tbl[i].state = PS_FAILED;
              nfail++;
            end
          end
        end
        push_word(ST_OK, act, 1'b0, '0, nfail, 1'b1);
      end
      K_PEER: begin
        if (n_used == 0 || act >= n_used) push_word(ST_INVALID, act, 1'b0, '0, '0, 1'b1);
        else if (same_addr(act, it)) push_word(ST_OK, act, 1'b0, '0, '0, 1'b1);
        else begin
          if ((it.now_ms - chg_time) < {48'd0, cfg.nrw}) nat = 1'b1;
          else chg_time = it.now_ms;
          predict_probe(it);
        end
      end
      K_MIG: begin
        if (cfg.role) push_word(ST_NOTALL, it.path_index, 1'b0, '0, '0, 1'b1);
        else if (it.path_index >= n_used || tbl[it.path_index].state != PS_VALIDATED)
          push_word(ST_INVALID, it.path_index, 1'b0, '0, '0, 1'b1);
        else begin
          act = it.path_index;
          push_word(ST_OK, it.path_index, 1'b0, '0, '0, 1'b1);
        end
      end
      default: push_word(ST_INVALID, act, 1'b0, '0, '0, 1'b1);
    endcase
  endtask

  // handshakes seen at the rising edge, used by the falling-edge drivers
  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && !in_stall;
    out_taken <= rst_n && out_valid && !out_stall;
  end

  // driver: one word from the pending queue, random gap before each
  int in_gap = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_taken) begin
        predict_event(in_data);
        words_sent++;
        if (pend_q.size() > 0 && in_gap == 0 && $urandom_range(0, 1)) begin
          in_data <= pend_q.pop_front();
        end else begin
          in_valid <= 1'b0;
          in_gap = $urandom_range(0, 18);
        end
      end else if (!in_valid && pend_q.size() > 0) begin
        if (in_gap > 0) in_gap--;
        else begin
          in_data <= pend_q.pop_front();
          in_valid <= 1'b1;
        end
      end
    end
  end

  // monitor and stall generator
  int out_gap = 0;
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      words_seen++;
      if (exp_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %p", out_data);
      end else begin
        out_t e;
        e = exp_q.pop_front();
        if (e !== out_data) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", e, out_data);
        end
      end
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else idle_cycles++;
  end

  always @(negedge clk) begin
    if (out_gap > 0) begin
      out_gap--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (out_taken) out_gap = $urandom_range(0, 18);
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= 20000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // wait until the block has drained, then a settling pause
  task automatic drain;
    while (pend_q.size() > 0 || in_valid || exp_q.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_ROLE: cfg.role = val[0];
      CFG_VTO:  cfg.vto = val;
      CFG_MAXC: cfg.maxc = val[3:0];
      default:  cfg.nrw = val;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic in_t rand_event(logic [63:0] now);
    in_t it;
    int a;
    it.kind = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(6, 7))
                                           : 3'($urandom_range(0, 5));
    if ($urandom_range(0, 9) == 0 && it.kind != K_TICK) it.kind = K_INIT;
    a = $urandom_range(0, 5);
    it.peer_is_v6 = a[0];
    it.peer_addr_hi = a[0] ? {32'hfe80_0000, 29'd0, 3'(a)} : {$urandom, $urandom};
    it.peer_addr_lo = (a == 5) ? {$urandom, $urandom} : {$urandom, 29'd0, 3'(a)};
    it.peer_port = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'd443 + 16'(a[1]);
    it.chal_word = {$urandom, $urandom};
    it.now_ms = ($urandom_range(0, 19) == 0) ? {$urandom, $urandom} : now;
    it.path_index = 2'($urandom);
    return it;
  endfunction

  initial begin
    in_t it;
    logic [63:0] clock_ms;
    logic [63:0] recent [$];
    for (int i = 0; i < MAX_PATHS; i++) tbl[i] = '0;
    n_used = '0; act = '0; nat = 1'b0; chg_time = '0;
    cfg.role = 1'b0; cfg.vto = 16'd3000; cfg.maxc = 4'd3; cfg.nrw = 16'd1000;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty table, init, probes to limit, responses, ticks, migrate
    it = '0;
    it.kind = K_PEER; pend_q.push_back(it);
    it.kind = K_MIG; pend_q.push_back(it);
    it.kind = K_TICK; it.now_ms = '1; pend_q.push_back(it);
    it.kind = 3'd7; pend_q.push_back(it);
    it = '0; it.kind = K_INIT; it.peer_addr_lo = 64'hc0a8_0001; it.peer_port = 16'hffff;
    pend_q.push_back(it);
    for (int i = 0; i < 4; i++) begin
      it = '0; it.kind = K_PROBE; it.peer_is_v6 = i[0];
      it.peer_addr_hi = i[0] ? '1 : '0; it.peer_addr_lo = '1 - i;
      it.chal_word = 64'h0123_4567_89ab_cdef + i; it.now_ms = 64'd10;
      pend_q.push_back(it);
    end
    it = '0; it.kind = K_RESP; it.chal_word = 64'h0123_4567_89ab_cdef;
    pend_q.push_back(it); pend_q.push_back(it);
    it.chal_word = '1; pend_q.push_back(it);
    it = '0; it.kind = K_TICK; it.now_ms = 64'd5000; it.chal_word = 64'h1122_3344_5566_7788;
    pend_q.push_back(it);
    it.now_ms = 64'd9000; pend_q.push_back(it);
    it.now_ms = 64'd13000; pend_q.push_back(it);
    it = '0; it.kind = K_MIG; it.path_index = 2'd1; pend_q.push_back(it);
    it.path_index = 2'd3; pend_q.push_back(it);
    it = '0; it.kind = K_PEER; it.peer_addr_lo = 64'hc0a8_0001; it.peer_port = 16'hffff;
    pend_q.push_back(it);
    it.peer_port = 16'd1; it.now_ms = 64'd20000; it.chal_word = 64'hdead;
    pend_q.push_back(it);
    it.peer_port = 16'd2; it.now_ms = 64'd20001; pend_q.push_back(it);
    it = '0; it.kind = K_INIT; pend_q.push_back(it);
    drain();

    // random phases across register settings, extremes included
    clock_ms = 64'd100;
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_ROLE, (ph == 3) ? 16'd1 : 16'd0);
      write_reg(CFG_VTO, (ph == 1) ? 16'd0 : (ph == 2) ? 16'hffff : 16'($urandom_range(1, 400)));
      write_reg(CFG_MAXC, (ph == 4) ? 16'd15 : (ph == 5) ? 16'd0 : 16'($urandom_range(1, 4)));
      write_reg(CFG_NRW, (ph == 6) ? 16'hffff : (ph == 7) ? 16'd0 : 16'($urandom_range(0, 300)));
      for (int n = 0; n < 50; n++) begin
        clock_ms += $urandom_range(0, 200);
        it = rand_event(clock_ms);
        // responses mostly echo a recently offered challenge
        if (it.kind == K_RESP && recent.size() > 0 && $urandom_range(0, 3) != 0)
          it.chal_word = recent[$urandom_range(0, recent.size() - 1)];
        recent.push_back(it.chal_word);
        for (int k = 1; k < 4; k++)
          recent.push_back((it.chal_word << (8 * k)) | (it.chal_word >> (64 - 8 * k)));
        while (recent.size() > 24) void'(recent.pop_front());
        pend_q.push_back(it);
      end
      drain();
    end

    $display("Covered %0d events and %0d result words over 9 register settings.",
             words_sent, words_seen);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
+incdir+sv
sv/qpv_pkg.sv
sv/qpv_slot_ram.sv
sv/qpv_ctrl.sv
sv/quic_path_validation_table_unit.sv
verif/testbench.sv
